>>> hdl/naive_dft_real_input_top_defines.svh
// Assertion macros for the direct DFT block.
// Needs a clock named clk and a synchronous reset named rst in the including module.
`ifndef NAIVE_DFT_REAL_INPUT_TOP_DEFINES_SVH
`define NAIVE_DFT_REAL_INPUT_TOP_DEFINES_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset
`define NDFT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ndft check failed");
// Implication checked at every clock edge out of reset
`define NDFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ndft check failed");
`else
`define NDFT_ASSERT(lbl, cond)
`define NDFT_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> hdl/ndft_pkg.sv
// Shared constants, types and twiddle tables for the direct DFT block.
// Self-contained; the twiddle tables are built at elaboration by a CORDIC.
`default_nettype none
package ndft_pkg;

  localparam int FRAME_LEN   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(FRAME_LEN);
  localparam int TW_W        = 16;
  localparam int PROD_W      = SAMPLE_BITS + TW_W;
  localparam int OUT_W       = 23;
  localparam int FRAC_SHIFT  = 15;
  localparam int ACC_SUM_W   = PROD_W + IDX_W + 1;
  localparam int ACC_W       = (ACC_SUM_W > FRAC_SHIFT + OUT_W) ?
                               ACC_SUM_W : FRAC_SHIFT + OUT_W;
  localparam int BIN_W       = 6;
  localparam int CORDIC_STEPS = 20;
  localparam longint CORDIC_GAIN = 64'sd652032874;

  typedef logic signed [TW_W-1:0] tw_tab_t [FRAME_LEN];
  typedef longint atan_tab_t [CORDIC_STEPS];

  localparam atan_tab_t ATAN_TAB = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  // Round a Q2.30 value to Q1.15 and clamp to +/-32767
  function automatic longint to_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32767) r = -64'sd32767;
    return r;
  endfunction

  // cos (sel_sin = 0) or sin (sel_sin = 1) of 2*pi*p/FRAME_LEN in Q1.15
  function automatic longint twiddle(input int p, input bit sel_sin);
    longint ang;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cr;
    longint sr;
    longint res;
    int quad;
    ang = (longint'(p) <<< 32) / FRAME_LEN;
    quad = int'((ang >>> 30) & 64'd3);
    z = ang & 64'h3FFFFFFF;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    cr = to_q15(x);
    sr = to_q15(y);
    case (quad)
      0: res = sel_sin ? sr : cr;
      1: res = sel_sin ? cr : -sr;
      2: res = sel_sin ? -sr : -cr;
      default: res = sel_sin ? -cr : sr;
    endcase
    return res;
  endfunction

  function automatic tw_tab_t build_tab(input bit sel_sin);
    tw_tab_t t;
    for (int p = 0; p < FRAME_LEN; p++) begin
      t[p] = TW_W'(twiddle(p, sel_sin));
    end
    return t;
  endfunction

  localparam tw_tab_t COS_TAB = build_tab(1'b0);
  localparam tw_tab_t SIN_TAB = build_tab(1'b1);

endpackage
`default_nettype wire

>>> hdl/naive_dft_real_input_top.sv
// Direct DFT of a real frame: sample store, twiddle lookup and one complex MAC.
// Depends on ndft_pkg and naive_dft_real_input_top_defines.svh.
//
// Usage:
// - Input channel (sample, in_valid, in_stall): one Q1.15 sample per word. in_stall is
//   high while a frame is being transformed; samples are taken one per cycle otherwise.
// - Output channel (bin_index, real_part, imag_part, out_valid, out_stall): after the
//   last sample of a frame the block emits FRAME_LEN bin words, k = 0 upwards, with
//   last_bin set on the final one.
// - Each bin takes FRAME_LEN reads of the sample memory, one per cycle, which feed the
//   shared multiply-accumulate pair; the pipeline then drains and the finished bin is
//   loaded into the output register. Samples of the next frame are not taken until
//   the last bin of the frame has been loaded.
// - The output word sits in a register; the next bin's accumulation runs while it
//   waits. If the receiver holds out_stall, the finished bin waits in the
//   accumulator until the output register frees.
// - Reset clears the fill count and control state; the sample memory is not
//   cleared, as every entry is written before it is read.
`default_nettype none
`include "naive_dft_real_input_top_defines.svh"
module naive_dft_real_input_top (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic signed [15:0]                       sample,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  output logic [ndft_pkg::BIN_W-1:0]                    bin_index,
  output logic signed [ndft_pkg::OUT_W-1:0]             real_part,
  output logic signed [ndft_pkg::OUT_W-1:0]             imag_part,
  output logic                                          last_bin,
  output logic                                          out_valid,
  input  wire logic                                     out_stall
);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_MAC   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  localparam logic [ndft_pkg::IDX_W-1:0] IDX_LAST =
    ndft_pkg::IDX_W'(ndft_pkg::FRAME_LEN - 1);

  state_t state;

  // Sample memory, one read port and one write port
  logic [ndft_pkg::SAMPLE_BITS-1:0] mem [ndft_pkg::FRAME_LEN];
  logic [ndft_pkg::SAMPLE_BITS-1:0] rdata;
  logic [ndft_pkg::SAMPLE_BITS-1:0] wdata;

  logic [ndft_pkg::IDX_W-1:0] fill_count;
  logic [ndft_pkg::IDX_W-1:0] m_cnt;
  logic [ndft_pkg::IDX_W-1:0] k_cnt;
  logic [ndft_pkg::IDX_W-1:0] p_cnt;
  logic [ndft_pkg::IDX_W:0]   p_sum;
  logic [ndft_pkg::IDX_W-1:0] p_next;

  logic                              s1_valid;
  logic                              s1_first;
  logic                              s1_last;
  logic signed [ndft_pkg::TW_W-1:0]  cos_r;
  logic signed [ndft_pkg::TW_W-1:0]  sin_r;
  logic                              s2_valid;
  logic                              s2_first;
  logic                              s2_last;
  logic signed [ndft_pkg::PROD_W-1:0] prod_re;
  logic signed [ndft_pkg::PROD_W-1:0] prod_im;
  logic signed [ndft_pkg::ACC_W-1:0]  acc_re;
  logic signed [ndft_pkg::ACC_W-1:0]  acc_im;
  logic                              bin_done;

  logic in_take;
  logic out_free;
  logic bin_load;

  assign in_stall = (state != S_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign bin_load = (state == S_DRAIN) && bin_done && out_free;

  // Low SAMPLE_BITS of the input word, zero-filled above 16 bits
  assign wdata = ndft_pkg::SAMPLE_BITS'({32'd0, sample[15:0]});

  // Phase step p + k modulo FRAME_LEN
  assign p_sum  = {1'b0, p_cnt} + {1'b0, k_cnt};
  assign p_next = (p_sum >= (ndft_pkg::IDX_W + 1)'(ndft_pkg::FRAME_LEN)) ?
                  ndft_pkg::IDX_W'(p_sum - (ndft_pkg::IDX_W + 1)'(ndft_pkg::FRAME_LEN)) :
                  p_sum[ndft_pkg::IDX_W-1:0];

  // Memory write on each accepted sample, read while issuing MACs
  always_ff @(posedge clk) begin
    if (in_take) begin
      mem[fill_count] <= wdata;
    end
    rdata <= mem[m_cnt];
  end

  // Sequencer: fill, issue reads, drain and hand over each bin
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      fill_count <= '0;
      m_cnt      <= '0;
      k_cnt      <= '0;
      p_cnt      <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_take) begin
            if (fill_count == IDX_LAST) begin
              fill_count <= '0;
              state      <= S_MAC;
              m_cnt      <= '0;
              k_cnt      <= '0;
              p_cnt      <= '0;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        S_MAC: begin
          p_cnt <= p_next;
          if (m_cnt == IDX_LAST) begin
            m_cnt <= '0;
            state <= S_DRAIN;
          end else begin
            m_cnt <= m_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (bin_load) begin
            p_cnt <= '0;
            if (k_cnt == IDX_LAST) begin
              k_cnt <= '0;
              state <= S_LOAD;
            end else begin
              k_cnt <= k_cnt + 1'b1;
              state <= S_MAC;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Stage 1: twiddle lookup alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == S_MAC);
    end
    s1_first <= (m_cnt == '0);
    s1_last  <= (m_cnt == IDX_LAST);
    cos_r    <= ndft_pkg::COS_TAB[p_cnt];
    sin_r    <= ndft_pkg::SIN_TAB[p_cnt];
  end

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod_re  <= ndft_pkg::PROD_W'($signed(rdata)) * ndft_pkg::PROD_W'(cos_r);
    prod_im  <= ndft_pkg::PROD_W'($signed(rdata)) * ndft_pkg::PROD_W'(sin_r);
  end

  // Stage 3: accumulate, flag the finished bin
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_done <= 1'b0;
    end else if (s2_valid && s2_last) begin
      bin_done <= 1'b1;
    end else if (bin_load) begin
      bin_done <= 1'b0;
    end
    if (s2_valid) begin
      acc_re <= (s2_first ? '0 : acc_re) + ndft_pkg::ACC_W'(prod_re);
      acc_im <= (s2_first ? '0 : acc_im) + ndft_pkg::ACC_W'(prod_im);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (bin_load) begin
      bin_index <= ndft_pkg::BIN_W'(k_cnt);
      real_part <= acc_re[ndft_pkg::FRAC_SHIFT +: ndft_pkg::OUT_W];
      imag_part <= acc_im[ndft_pkg::FRAC_SHIFT +: ndft_pkg::OUT_W];
      last_bin  <= (k_cnt == IDX_LAST);
    end
  end

  // Checks
  `NDFT_ASSERT_IMP(a_idle_pipe_empty, !in_stall, !s1_valid && !s2_valid && !bin_done)
  `NDFT_ASSERT_IMP(a_done_no_flight, bin_done, !s1_valid && !s2_valid)
  `NDFT_ASSERT_IMP(a_last_is_top_bin, out_valid && last_bin,
                   bin_index == ndft_pkg::BIN_W'(ndft_pkg::FRAME_LEN - 1))
  `NDFT_ASSERT_IMP(a_load_after_done, bin_load, bin_done && (state == S_DRAIN))

endmodule
`default_nettype wire

>>> bench/tb_naive_dft_real_input_top.sv
// Self-checking bench for the direct real-input DFT block: whole frames of samples go in,
// and every bin word that comes out is checked against a bit-exact predictor in this file.
// Depends on ndft_pkg (frame length and port widths) and the RTL of naive_dft_real_input_top.
`default_nettype none
module tb_naive_dft_real_input_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N      = ndft_pkg::FRAME_LEN;
  localparam int OUT_W  = ndft_pkg::OUT_W;
  localparam int BIN_W  = ndft_pkg::BIN_W;
  localparam int LAT    = N + 3;
  localparam int ROT_STEPS = 20;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint ARCTAN [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NEG_FULL,
    SHAPE_ALTERNATE,
    SHAPE_SMALL,
    SHAPE_IMPULSE
  } frame_shape_t;

  typedef struct {
    logic [BIN_W-1:0]        k;
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    last;
  } bin_word_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic signed [15:0]      sample = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [BIN_W-1:0]        bin_index;
  logic signed [OUT_W-1:0] real_part;
  logic signed [OUT_W-1:0] imag_part;
  logic                    last_bin;
  logic                    out_valid;
  logic                    out_stall = 1'b0;

  // predictor state
  longint             cos_q15 [N];
  longint             sin_q15 [N];
  logic signed [15:0] frame_buf [N];
  int                 fill_cnt = 0;
  bin_word_t          bins_due [$];
  logic signed [15:0] pending [$];

  int errors = 0;
  int samples_taken = 0;
  int frames_done = 0;
  int bins_checked = 0;

  naive_dft_real_input_top dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .bin_index (bin_index),
    .real_part (real_part),
    .imag_part (imag_part),
    .last_bin  (last_bin),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Q2.30 rounded to Q1.15, clamped so that 1.0 reads as 32767
  function automatic longint sat_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32767) r = -64'sd32767;
    return r;
  endfunction

  // Mostly no pause, often a short one, now and then a long one; none while calm
  function automatic int pick_pause(input int calm);
    int r;
    if (calm > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Takes one sample; the last of a frame queues all N bins of the transform
  function automatic void absorb_sample(input logic signed [15:0] s);
    longint    acc_re;
    longint    acc_im;
    int        p;
    bin_word_t w;
    frame_buf[fill_cnt] = s;
    if (fill_cnt < N - 1) begin
      fill_cnt++;
      return;
    end
    fill_cnt = 0;
    frames_done++;
    for (int k = 0; k < N; k++) begin
      acc_re = 0;
      acc_im = 0;
      p = 0;
      for (int m = 0; m < N; m++) begin
        acc_re += longint'(frame_buf[m]) * cos_q15[p];
        acc_im += longint'(frame_buf[m]) * sin_q15[p];
        p = (p + k) % N;
      end
      w.k    = BIN_W'(k);
      w.re   = OUT_W'(acc_re >>> 15);
      w.im   = OUT_W'(acc_im >>> 15);
      w.last = (k == N - 1);
      bins_due.push_back(w);
    end
  endfunction

  function automatic logic signed [15:0] shaped_sample(input frame_shape_t shape,
                                                       input int m, input int spike);
    case (shape)
      SHAPE_NEG_FULL:  return 16'sh8000;
      SHAPE_ALTERNATE: return m[0] ? 16'sh8000 : 16'sh7FFF;
      SHAPE_SMALL:     return 16'($signed($urandom_range(0, 511)) - 256);
      SHAPE_IMPULSE:   return (m == spike) ? 16'sh7FFF : 16'sh0000;
      default:         return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Twiddle tables: quadrant from the top angle bits, CORDIC on the rest
  initial begin : twiddle_gen
    longint ang;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cq;
    longint sq;
    int     quad;
    for (int p = 0; p < N; p++) begin
      ang  = (longint'(p) << 32) / N;
      quad = int'((ang >> 30) & 64'd3);
      z    = ang & 64'h3FFF_FFFF;
      x    = ROT_GAIN;
      y    = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ARCTAN[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ARCTAN[i];
        end
      end
      cq = sat_q15(x);
      sq = sat_q15(y);
      case (quad)
        0: begin
          cos_q15[p] = cq;
          sin_q15[p] = sq;
        end
        1: begin
          cos_q15[p] = -sq;
          sin_q15[p] = cq;
        end
        2: begin
          cos_q15[p] = -cq;
          sin_q15[p] = -sq;
        end
        default: begin
          cos_q15[p] = sq;
          sin_q15[p] = -cq;
        end
      endcase
    end
  end

  // Input driver: a word leaves the queue once the previous one is taken
  int in_gap = 0;
  int in_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 199) == 0) in_calm = $urandom_range(100, 400);
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          samples_taken++;
          absorb_sample(sample);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          sample   <= pending.pop_front();
          in_valid <= 1'b1;
          in_gap   = pick_pause(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each taken bin word, and stalls at random
  int stall_left = 0;
  int out_calm = 0;
  always @(posedge clk) begin
    bin_word_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (bins_due.size() == 0) begin
          report_mismatch("unexpected bin word, index", bin_index, -1);
        end else begin
          w = bins_due.pop_front();
          bins_checked++;
          if (bin_index !== w.k) report_mismatch("bin_index", bin_index, w.k);
          if (real_part !== w.re) report_mismatch("real_part", real_part, w.re);
          if (imag_part !== w.im) report_mismatch("imag_part", imag_part, w.im);
          if (last_bin !== w.last) report_mismatch("last_bin", last_bin, w.last);
        end
      end
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 199) == 0) out_calm = $urandom_range(100, 400);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_pause(out_calm);
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic signed [15:0] corner [12];
    frame_shape_t       shape;
    int                 spike;
    corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
               16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh4000, 16'shC000, 16'sh7FFE};
    // first frame opens on the field extremes and bit patterns
    foreach (corner[i]) pending.push_back(corner[i]);
    for (int m = 12; m < N; m++) pending.push_back(shaped_sample(SHAPE_RANDOM, m, 0));
    // full-scale constant and alternating frames, then one of random shape
    for (int m = 0; m < N; m++) pending.push_back(shaped_sample(SHAPE_NEG_FULL, m, 0));
    for (int m = 0; m < N; m++) pending.push_back(shaped_sample(SHAPE_ALTERNATE, m, 0));
    shape = frame_shape_t'($urandom_range(SHAPE_RANDOM, SHAPE_IMPULSE));
    spike = $urandom_range(0, N - 1);
    for (int m = 0; m < N; m++) pending.push_back(shaped_sample(shape, m, spike));
    // a partial frame that must not produce anything
    for (int m = 0; m < 14; m++) pending.push_back(shaped_sample(SHAPE_RANDOM, m, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (bins_due.size() != 0) @(posedge clk);
    repeat (3 * LAT) @(posedge clk);

    $display("tb: %0d samples taken, %0d frames transformed, %0d bin words checked",
             samples_taken, frames_done, bins_checked);
    $display("tb: frames covered extremes, full-scale constant and alternating input");
    if (errors == 0 && bins_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #800000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
